// ===== design/fmsd_pkg.sv =====
`timescale 1ns / 1ps
package fmsd_pkg;

    localparam int ALPHABET          = 256;
    localparam int SYM_WIDTH         = 8;
    localparam int COUNT_WIDTH_DEF   = 24;
    localparam int CMD_WIDTH         = 3;

    localparam logic [SYM_WIDTH-1:0] NEWLINE_BYTE = 8'd10;
    localparam logic [SYM_WIDTH-1:0] SPACE_BYTE   = 8'd32;
    localparam logic [SYM_WIDTH-1:0] FILL_RESET   = 8'd63;
    localparam logic [8:0]           RANKS_RESET  = 9'd20;

    localparam logic [CMD_WIDTH-1:0] CMD_CLEAR     = 3'd0;
    localparam logic [CMD_WIDTH-1:0] CMD_COUNT_CIPH = 3'd1;
    localparam logic [CMD_WIDTH-1:0] CMD_COUNT_REF = 3'd2;
    localparam logic [CMD_WIDTH-1:0] CMD_BUILD     = 3'd3;
    localparam logic [CMD_WIDTH-1:0] CMD_DECODE    = 3'd4;

    localparam logic REG_RANKS = 1'b0;
    localparam logic REG_FILL  = 1'b1;

endpackage

// ===== design/fmsd_ram.sv =====
`timescale 1ns / 1ps
module fmsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/frequency_match_substitution_decoder.sv =====
`timescale 1ns / 1ps
// Byte-histogram substitution decoder. Words on the slave stream carry a command in
// tuser and a byte in tdata. Count and decode words each take a histogram or table read,
// then the write-back or result; a decode word is held longer while the output register
// still waits to be taken. A decode word produces one output word holding the substituted
// byte, all other commands produce none. A clear command clears both histograms, and after
// reset an initial pass clears the histograms and sets every table entry to 63 before the
// first word is taken. A build ranks both histograms by counting, for every byte, how many
// bytes precede it, in 256 passes over the histogram memories, then writes the table.
// The input stays stalled during clear and build passes.
module frequency_match_substitution_decoder
    import fmsd_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // data_byte[7:0]
    input  logic [CMD_WIDTH-1:0] s_tuser,   // cmd[2:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,   // out_byte[7:0]
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    typedef enum logic [3:0] {
        S_INIT, S_CLR, S_IDLE, S_CNT_WR, S_DEC,
        S_RK_HEAD, S_RK_KEY, S_RK_SWEEP, S_RK_WB,
        S_MP_A, S_MP_B, S_MP_C, S_MP_D
    } state_t;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    state_t                 state_reg;
    logic [8:0]             ranks_reg;
    logic [SYM_WIDTH-1:0]   fill_reg;
    logic [SYM_WIDTH-1:0]   idx_reg;
    logic [SYM_WIDTH-1:0]   b_reg;
    logic [8:0]             cnt_reg;
    logic                   pend_reg;
    logic [SYM_WIDTH-1:0]   pidx_reg;
    logic [COUNT_WIDTH-1:0] ckey_reg;
    logic [COUNT_WIDTH-1:0] rkey_reg;
    logic [SYM_WIDTH-1:0]   crank_reg;
    logic [SYM_WIDTH-1:0]   rrank_reg;
    logic [SYM_WIDTH-1:0]   rank_reg;
    logic [SYM_WIDTH-1:0]   sym_reg;
    logic                   ref_sel_reg;
    logic                   out_valid_reg;
    logic [SYM_WIDTH-1:0]   out_byte_reg;

    logic                   hc_en, hc_we, hr_en, hr_we, tb_en, tb_we;
    logic                   ck_en, ck_we, ri_en, ri_we;
    logic [SYM_WIDTH-1:0]   hc_addr, hr_addr, tb_addr, ck_addr, ri_addr;
    logic [COUNT_WIDTH-1:0] hc_wdata, hr_wdata, hc_rdata, hr_rdata;
    logic [SYM_WIDTH-1:0]   tb_wdata, tb_rdata, ck_wdata, ck_rdata, ri_wdata, ri_rdata;
    logic [COUNT_WIDTH-1:0] inc_src;
    logic [COUNT_WIDTH-1:0] inc_val;
    logic                   accept;
    logic                   out_load;
    logic                   c_before, r_before;
    logic [SYM_WIDTH-1:0]   map_val;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign pready   = 1'b1;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign out_load = (state_reg == S_DEC) && (!out_valid_reg || m_tready);

    always_comb
    begin
        case (paddr[2])
            REG_RANKS: prdata = {23'd0, ranks_reg};
            default:   prdata = {24'd0, fill_reg};
        endcase
    end

    assign inc_src = ref_sel_reg ? hr_rdata : hc_rdata;
    assign inc_val = (inc_src == COUNT_MAX) ? inc_src : inc_src + 1'b1;

    // earlier rank: larger count, or equal count and lower byte
    assign c_before = (hc_rdata > ckey_reg) || ((hc_rdata == ckey_reg) && (pidx_reg < b_reg));
    assign r_before = (hr_rdata > rkey_reg) || ((hr_rdata == rkey_reg) && (pidx_reg < b_reg));

    always_comb
    begin
        if (idx_reg == NEWLINE_BYTE || idx_reg == SPACE_BYTE)
        begin
            map_val = idx_reg;
        end
        else if (({1'b0, rank_reg} < ranks_reg) && (hr_rdata != '0))
        begin
            map_val = sym_reg;
        end
        else
        begin
            map_val = fill_reg;
        end
    end

    always_comb
    begin
        hc_en = 1'b0; hc_we = 1'b0; hc_addr = idx_reg; hc_wdata = '0;
        hr_en = 1'b0; hr_we = 1'b0; hr_addr = idx_reg; hr_wdata = '0;
        tb_en = 1'b0; tb_we = 1'b0; tb_addr = idx_reg; tb_wdata = FILL_RESET;
        ck_en = 1'b0; ck_we = 1'b0; ck_addr = idx_reg; ck_wdata = crank_reg;
        ri_en = 1'b0; ri_we = 1'b0; ri_addr = rrank_reg; ri_wdata = b_reg;
        case (state_reg)
            S_INIT:
            begin
                hc_en = 1'b1; hc_we = 1'b1;
                hr_en = 1'b1; hr_we = 1'b1;
                tb_en = 1'b1; tb_we = 1'b1;
            end
            S_CLR:
            begin
                hc_en = 1'b1; hc_we = 1'b1;
                hr_en = 1'b1; hr_we = 1'b1;
            end
            S_IDLE:
            begin
                hc_addr = s_tdata;
                hr_addr = s_tdata;
                tb_addr = s_tdata;
                hc_en = accept && (s_tuser == CMD_COUNT_CIPH);
                hr_en = accept && (s_tuser == CMD_COUNT_REF);
                tb_en = accept && (s_tuser == CMD_DECODE);
            end
            S_CNT_WR:
            begin
                hc_addr = sym_reg; hc_wdata = inc_val;
                hr_addr = sym_reg; hr_wdata = inc_val;
                hc_en = !ref_sel_reg; hc_we = !ref_sel_reg;
                hr_en = ref_sel_reg;  hr_we = ref_sel_reg;
            end
            S_RK_HEAD:
            begin
                hc_en = 1'b1; hc_addr = b_reg;
                hr_en = 1'b1; hr_addr = b_reg;
            end
            S_RK_SWEEP:
            begin
                hc_en = !cnt_reg[8]; hc_addr = cnt_reg[7:0];
                hr_en = !cnt_reg[8]; hr_addr = cnt_reg[7:0];
            end
            S_RK_WB:
            begin
                ck_en = 1'b1; ck_we = 1'b1; ck_addr = b_reg;
                ri_en = 1'b1; ri_we = 1'b1;
            end
            S_MP_A:
            begin
                ck_en = 1'b1;
            end
            S_MP_B:
            begin
                ri_en = 1'b1; ri_addr = ck_rdata;
            end
            S_MP_C:
            begin
                hr_en = 1'b1; hr_addr = ri_rdata;
            end
            S_MP_D:
            begin
                tb_en = 1'b1; tb_we = 1'b1; tb_wdata = map_val;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            ranks_reg     <= RANKS_RESET;
            fill_reg      <= FILL_RESET;
            idx_reg       <= '0;
            b_reg         <= '0;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (psel && penable && pwrite)
            begin
                case (paddr[2])
                    REG_RANKS: ranks_reg <= pwdata[8:0];
                    default:   fill_reg  <= pwdata[7:0];
                endcase
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                out_byte_reg  <= tb_rdata;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_INIT, S_CLR:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == SYM_WIDTH'(ALPHABET - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    idx_reg <= '0;
                    b_reg   <= '0;
                    sym_reg <= s_tdata;
                    if (accept)
                    begin
                        case (s_tuser)
                            CMD_CLEAR:      state_reg <= S_CLR;
                            CMD_COUNT_CIPH:
                            begin
                                ref_sel_reg <= 1'b0;
                                state_reg   <= S_CNT_WR;
                            end
                            CMD_COUNT_REF:
                            begin
                                ref_sel_reg <= 1'b1;
                                state_reg   <= S_CNT_WR;
                            end
                            CMD_BUILD:      state_reg <= S_RK_HEAD;
                            CMD_DECODE:     state_reg <= S_DEC;
                            default:        state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_CNT_WR:
                begin
                    state_reg <= S_IDLE;
                end
                S_DEC:
                begin
                    // hold the table read until the output register frees up
                    if (out_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_RK_HEAD:
                begin
                    state_reg <= S_RK_KEY;
                end
                S_RK_KEY:
                begin
                    ckey_reg  <= hc_rdata;
                    rkey_reg  <= hr_rdata;
                    crank_reg <= '0;
                    rrank_reg <= '0;
                    cnt_reg   <= '0;
                    pend_reg  <= 1'b0;
                    state_reg <= S_RK_SWEEP;
                end
                S_RK_SWEEP:
                begin
                    pend_reg <= !cnt_reg[8];
                    pidx_reg <= cnt_reg[7:0];
                    if (!cnt_reg[8])
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    if (pend_reg)
                    begin
                        crank_reg <= crank_reg + SYM_WIDTH'(c_before);
                        rrank_reg <= rrank_reg + SYM_WIDTH'(r_before);
                    end
                    if (cnt_reg[8] && !pend_reg)
                    begin
                        state_reg <= S_RK_WB;
                    end
                end
                S_RK_WB:
                begin
                    b_reg <= b_reg + 1'b1;
                    if (b_reg == SYM_WIDTH'(ALPHABET - 1))
                    begin
                        state_reg <= S_MP_A;
                    end
                    else
                    begin
                        state_reg <= S_RK_HEAD;
                    end
                end
                S_MP_A:
                begin
                    state_reg <= S_MP_B;
                end
                S_MP_B:
                begin
                    rank_reg  <= ck_rdata;
                    state_reg <= S_MP_C;
                end
                S_MP_C:
                begin
                    sym_reg   <= ri_rdata;
                    state_reg <= S_MP_D;
                end
                S_MP_D:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == SYM_WIDTH'(ALPHABET - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_MP_A;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    fmsd_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(ALPHABET)) u_hist_cipher (
        .clk(clk), .en(hc_en), .we(hc_we), .addr(hc_addr), .wdata(hc_wdata), .rdata(hc_rdata)
    );

    fmsd_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(ALPHABET)) u_hist_ref (
        .clk(clk), .en(hr_en), .we(hr_we), .addr(hr_addr), .wdata(hr_wdata), .rdata(hr_rdata)
    );

    fmsd_ram #(.WIDTH(SYM_WIDTH), .DEPTH(ALPHABET)) u_code_table (
        .clk(clk), .en(tb_en), .we(tb_we), .addr(tb_addr), .wdata(tb_wdata), .rdata(tb_rdata)
    );

    fmsd_ram #(.WIDTH(SYM_WIDTH), .DEPTH(ALPHABET)) u_cipher_rank (
        .clk(clk), .en(ck_en), .we(ck_we), .addr(ck_addr), .wdata(ck_wdata), .rdata(ck_rdata)
    );

    fmsd_ram #(.WIDTH(SYM_WIDTH), .DEPTH(ALPHABET)) u_ref_by_rank (
        .clk(clk), .en(ri_en), .we(ri_we), .addr(ri_addr), .wdata(ri_wdata), .rdata(ri_rdata)
    );

endmodule
